@@ rtl/sbd_pkg.sv @@
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types, constants and the microcode program for the bounded draw.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int BOUND_W = 32;
  localparam int WORD_W  = 64;
  localparam int STEP_W  = 4;
  localparam int ADDR_W  = 4;
  localparam int CNT_W   = $clog2(BOUND_W + 1);

  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int SH_ADV  = 30;
  localparam int SH_MIX  = 27;
  localparam int SH_FIN  = 31;

  localparam logic [ADDR_W-1:0] REG_SEED = 4'h0;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {OPA_ZL, OPA_ZH, OPA_TOP} opa_t;
  typedef enum logic [2:0] {OPB_AL, OPB_AH, OPB_BL, OPB_BH, OPB_N} opb_t;
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADDHI} acc_op_t;
  typedef enum logic [1:0] {Z_NONE, Z_ADV, Z_XS27} z_op_t;
  typedef enum logic [2:0] {BR_NEXT, BR_IDLE, BR_TEST, BR_WAIT, BR_OUT} br_t;

  typedef struct packed {
    opa_t    opa;
    opb_t    opb;
    logic    mul_en;
    acc_op_t acc;
    z_op_t   zop;
    br_t     br;
    step_t   tgt;
  } uword_t;

  typedef struct packed {
    opa_t    opa;
    opb_t    opb;
    logic    mul_en;
    acc_op_t acc;
    z_op_t   zop;
    logic    in_ready;
    logic    in_take;
    logic    div_start;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic lo_ge_n;
    logic lo_ge_thr;
    logic thr_valid;
    logic div_busy;
  } stat_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_ADV   = 4'd1;
  localparam step_t S_M1A   = 4'd2;
  localparam step_t S_M2A   = 4'd3;
  localparam step_t S_M3A   = 4'd4;
  localparam step_t S_ACCA  = 4'd5;
  localparam step_t S_XS27  = 4'd6;
  localparam step_t S_M1B   = 4'd7;
  localparam step_t S_M2B   = 4'd8;
  localparam step_t S_M3B   = 4'd9;
  localparam step_t S_ACCB  = 4'd10;
  localparam step_t S_MULN  = 4'd11;
  localparam step_t S_TEST  = 4'd12;
  localparam step_t S_DIVW  = 4'd13;
  localparam step_t S_OUT   = 4'd14;

  function automatic uword_t uw(opa_t a, opb_t b, logic m, acc_op_t c, z_op_t z,
                                br_t br, step_t t);
    uword_t w;
    w.opa    = a;
    w.opb    = b;
    w.mul_en = m;
    w.acc    = c;
    w.zop    = z;
    w.br     = br;
    w.tgt    = t;
    return w;
  endfunction

  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      S_IDLE: w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_NONE,  Z_NONE, BR_IDLE, S_ADV);
      S_ADV:  w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_NONE,  Z_ADV,  BR_NEXT, S_IDLE);
      S_M1A:  w = uw(OPA_ZL,  OPB_AL, 1'b1, ACC_NONE,  Z_NONE, BR_NEXT, S_IDLE);
      S_M2A:  w = uw(OPA_ZH,  OPB_AL, 1'b1, ACC_LOAD,  Z_NONE, BR_NEXT, S_IDLE);
      S_M3A:  w = uw(OPA_ZL,  OPB_AH, 1'b1, ACC_ADDHI, Z_NONE, BR_NEXT, S_IDLE);
      S_ACCA: w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_ADDHI, Z_NONE, BR_NEXT, S_IDLE);
      S_XS27: w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_NONE,  Z_XS27, BR_NEXT, S_IDLE);
      S_M1B:  w = uw(OPA_ZL,  OPB_BL, 1'b1, ACC_NONE,  Z_NONE, BR_NEXT, S_IDLE);
      S_M2B:  w = uw(OPA_ZH,  OPB_BL, 1'b1, ACC_LOAD,  Z_NONE, BR_NEXT, S_IDLE);
      S_M3B:  w = uw(OPA_ZL,  OPB_BH, 1'b1, ACC_ADDHI, Z_NONE, BR_NEXT, S_IDLE);
      S_ACCB: w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_ADDHI, Z_NONE, BR_NEXT, S_IDLE);
      S_MULN: w = uw(OPA_TOP, OPB_N,  1'b1, ACC_NONE,  Z_NONE, BR_NEXT, S_IDLE);
      S_TEST: w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_NONE,  Z_NONE, BR_TEST, S_ADV);
      S_DIVW: w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_NONE,  Z_NONE, BR_WAIT, S_TEST);
      S_OUT:  w = uw(OPA_ZL,  OPB_AL, 1'b0, ACC_NONE,  Z_NONE, BR_OUT,  S_IDLE);
      default: w = uw(OPA_ZL, OPB_AL, 1'b0, ACC_NONE,  Z_NONE, BR_NEXT, S_IDLE);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/sbd_in_if.sv @@
// ----------------------------------------------------------------------------
// sbd_in_if
// Input channel: one bound per item.
// ----------------------------------------------------------------------------
interface sbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbd_pkg::BOUND_W-1:0]  bound;

  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

@@ rtl/sbd_out_if.sv @@
// ----------------------------------------------------------------------------
// sbd_out_if
// Result channel: one drawn value per item.
// ----------------------------------------------------------------------------
interface sbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbd_pkg::BOUND_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/splitmix64_bounded_draw_top.sv @@
// The next bound is taken only after the result is registered.
// Each redraw takes seven passes through the shared 32x32 multiplier.
// The first rejection also waits for the bit-serial threshold remainder.
// Synchronous active-low reset clears the sequencer, seed and state to zero.
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw_top
// Unbiased draws in [0, bound) from a splitmix64 generator, microcoded.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw_top (
  input  logic                         clk,
  input  logic                         rst_n,
  sbd_in_if.sink                       in_ch,
  sbd_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sbd_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [sbd_pkg::WORD_W-1:0]   cfg_pwdata,
  output logic [sbd_pkg::WORD_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import sbd_pkg::*;

  ctrl_t             ctrl;
  stat_t             stat;
  logic              cfg_wr;
  logic [WORD_W-1:0] seed;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_SEED);
  assign cfg_prdata = (cfg_paddr == REG_SEED) ? seed : '0;

  sbd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  sbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_wr    (cfg_wr),
    .cfg_wdata (cfg_pwdata),
    .seed      (seed),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_start |-> !stat.thr_valid)
    else $error("threshold requested twice for one item");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_start |=> stat.div_busy)
    else $error("remainder unit did not start");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_ch.valid)
    else $error("loaded result not presented");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.in_take |=> !ctrl.in_ready)
    else $error("item taken while previous item in flight");
endmodule

@@ rtl/sbd_rem.sv @@
// ----------------------------------------------------------------------------
// sbd_rem
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sbd_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sbd_pkg::BOUND_W-1:0]  dividend,
  input  logic [sbd_pkg::BOUND_W-1:0]  divisor,
  output logic [sbd_pkg::BOUND_W-1:0]  rem,
  output logic                         busy
);
  import sbd_pkg::*;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BOUND_W-1:0] rem_r, rem_nxt;
  logic [BOUND_W-1:0] dq_r, dq_nxt;
  logic [BOUND_W:0]   trial;

  assign trial = {rem_r, dq_r[BOUND_W-1]};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    if (start) begin
      cnt_nxt = CNT_W'(BOUND_W);
      rem_nxt = '0;
      dq_nxt  = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dq_nxt  = {dq_r[BOUND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = BOUND_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[BOUND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign rem  = rem_r;
  assign busy = (cnt_r != '0);
endmodule

@@ rtl/sbd_dp.sv @@
// ----------------------------------------------------------------------------
// sbd_dp
// Datapath: generator state, shared 32x32 multiplier, accumulator,
// threshold unit and result register.
// ----------------------------------------------------------------------------
module sbd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sbd_pkg::ctrl_t               ctrl,
  output sbd_pkg::stat_t               stat,
  input  logic                         cfg_wr,
  input  logic [sbd_pkg::WORD_W-1:0]   cfg_wdata,
  output logic [sbd_pkg::WORD_W-1:0]   seed,
  sbd_in_if.sink                       in_ch,
  sbd_out_if.source                    out_ch
);
  import sbd_pkg::*;

  logic [WORD_W-1:0]  seed_r, state_r, state_nxt, z_r, z_nxt, acc_r, acc_nxt;
  logic [WORD_W-1:0]  p_r, p_nxt, adv, fin;
  logic [BOUND_W-1:0] n_r, value_r, opa_v, opb_v, thr, lo;
  logic               thr_valid_r, out_valid_r, out_valid_nxt, div_busy;

  assign adv = state_r + GOLDEN_INC;
  assign fin = acc_r >> SH_FIN;

  always_comb begin
    unique case (ctrl.opa)
      OPA_ZL:  opa_v = z_r[BOUND_W-1:0];
      OPA_ZH:  opa_v = z_r[WORD_W-1:BOUND_W];
      OPA_TOP: opa_v = acc_r[WORD_W-1:BOUND_W] ^ fin[WORD_W-1:BOUND_W];
      default: opa_v = '0;
    endcase
    unique case (ctrl.opb)
      OPB_AL:  opb_v = MIX_MUL_A[BOUND_W-1:0];
      OPB_AH:  opb_v = MIX_MUL_A[WORD_W-1:BOUND_W];
      OPB_BL:  opb_v = MIX_MUL_B[BOUND_W-1:0];
      OPB_BH:  opb_v = MIX_MUL_B[WORD_W-1:BOUND_W];
      OPB_N:   opb_v = n_r;
      default: opb_v = '0;
    endcase
  end

  always_comb begin
    p_nxt = ctrl.mul_en ? ({{BOUND_W{1'b0}}, opa_v} * {{BOUND_W{1'b0}}, opb_v}) : p_r;

    unique case (ctrl.acc)
      ACC_LOAD:  acc_nxt = p_r;
      ACC_ADDHI: acc_nxt = acc_r + {p_r[BOUND_W-1:0], {BOUND_W{1'b0}}};
      default:   acc_nxt = acc_r;
    endcase

    state_nxt = state_r;
    z_nxt     = z_r;
    if (cfg_wr) begin
      state_nxt = cfg_wdata;
    end else begin
      unique case (ctrl.zop)
        Z_ADV: begin
          state_nxt = adv;
          z_nxt     = adv ^ (adv >> SH_ADV);
        end
        Z_XS27:  z_nxt = acc_r ^ (acc_r >> SH_MIX);
        default: z_nxt = z_r;
      endcase
    end

    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  sbd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (BOUND_W'(0) - n_r),
    .divisor  (n_r),
    .rem      (thr),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      state_r     <= '0;
      thr_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        seed_r <= cfg_wdata;
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctrl.in_take) begin
        thr_valid_r <= 1'b0;
      end else if (ctrl.div_start) begin
        thr_valid_r <= 1'b1;
      end
    end
    z_r   <= z_nxt;
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
    if (ctrl.in_take) begin
      n_r <= in_ch.bound;
    end
    if (ctrl.out_load) begin
      value_r <= p_r[WORD_W-1:BOUND_W];
    end
  end

  assign lo = p_r[BOUND_W-1:0];

  assign stat.in_valid  = in_ch.valid;
  assign stat.out_free  = !out_valid_r || out_ch.ready;
  assign stat.lo_ge_n   = (lo >= n_r);
  assign stat.lo_ge_thr = (lo >= thr);
  assign stat.thr_valid = thr_valid_r;
  assign stat.div_busy  = div_busy;

  assign in_ch.ready  = ctrl.in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = value_r;
  assign seed         = seed_r;
endmodule

@@ rtl/sbd_seq.sv @@
// ----------------------------------------------------------------------------
// sbd_seq
// Microcode sequencer: step counter, program table and branch logic.
// ----------------------------------------------------------------------------
module sbd_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  sbd_pkg::stat_t  stat,
  output sbd_pkg::ctrl_t  ctrl
);
  import sbd_pkg::*;

  step_t  pc_r, pc_nxt;
  uword_t w;

  always_comb begin
    w              = ucode(pc_r);
    ctrl.opa       = w.opa;
    ctrl.opb       = w.opb;
    ctrl.mul_en    = w.mul_en;
    ctrl.acc       = w.acc;
    ctrl.zop       = w.zop;
    ctrl.in_ready  = 1'b0;
    ctrl.in_take   = 1'b0;
    ctrl.div_start = 1'b0;
    ctrl.out_load  = 1'b0;
    pc_nxt         = pc_r;
    unique case (w.br)
      BR_NEXT: pc_nxt = pc_r + 1'b1;
      BR_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (stat.in_valid) begin
          ctrl.in_take = 1'b1;
          pc_nxt       = w.tgt;
        end
      end
      BR_TEST: begin
        priority if (stat.thr_valid) begin
          pc_nxt = stat.lo_ge_thr ? S_OUT : w.tgt;
        end else if (stat.lo_ge_n) begin
          pc_nxt = S_OUT;
        end else begin
          ctrl.div_start = 1'b1;
          pc_nxt         = S_DIVW;
        end
      end
      BR_WAIT: pc_nxt = stat.div_busy ? pc_r : w.tgt;
      BR_OUT: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          pc_nxt        = w.tgt;
        end
      end
      default: pc_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end
endmodule
